// ===== hdl/prrcs_pkg.sv =====
// shared types and constants for the priority round-robin call scanner
// no dependencies; imported by the channel interfaces and the scanner

package prrcs_pkg;

   localparam int DEVICE_W    = 7;
   localparam int SHOWN_DEV_W = 6;
   localparam int PTR_W       = 7;
   localparam int TICK_W      = 16;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [TICK_W-1:0] SCROLL_RESET = 16'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_TICKS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIAL_EN    = 8'd1;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_STORE  = 2'd1,
      CMD_NEWREQ = 2'd2,
      CMD_MODE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_SCAN   = 2'd0,
      MODE_HOLD   = 2'd1,
      MODE_NEWREQ = 2'd2,
      MODE_WAIT   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      EV_CANCEL    = 2'd0,
      EV_CALL      = 2'd1,
      EV_ASSIST    = 2'd2,
      EV_EMERGENCY = 2'd3
   } event_type;

endpackage

// ===== hdl/prrcs_channels.sv =====
// valid/ready channel interfaces: request, response and register write
// depends on prrcs_pkg

interface prrcs_req_if import prrcs_pkg::*; ();
   logic                valid;
   logic                ready;
   cmd_type             cmd;
   logic [DEVICE_W-1:0] device;
   event_type           event_code;
   mode_type            mode_value;

   modport source (output valid, output cmd, output device, output event_code,
                   output mode_value, input ready);
   modport sink   (input valid, input cmd, input device, input event_code,
                   input mode_value, output ready);
endinterface

interface prrcs_rsp_if import prrcs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   shown_valid;
   event_type              shown_event;
   logic [SHOWN_DEV_W-1:0] shown_device;
   mode_type               queue_mode;

   modport source (output valid, output shown_valid, output shown_event,
                   output shown_device, output queue_mode, input ready);
   modport sink   (input valid, input shown_valid, input shown_event,
                   input shown_device, input queue_mode, output ready);
endinterface

interface prrcs_csr_if import prrcs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/prrcs_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module prrcs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/priority_round_robin_call_scanner.sv =====
// priority round-robin call scanner, top level
// depends on prrcs_pkg, prrcs_channels (interfaces) and prrcs_ram
//
// One request is taken at a time. A store, new-request, set-mode request, a disabled
// tick, or a tick outside scan mode goes via the emit state to the output register.
// A tick in scan mode walks the event table once through the table ram's single read
// port, one device per cycle, collecting the first emergency and the first call or
// assist in round-robin order from the scan pointer, then goes through the last,
// final and emit states. A finished response sits in the output register, and the
// next request is accepted while it waits. Each table entry has a valid flag cleared
// by reset, so an unwritten entry reads as cancel and no clearing pass is needed.
// Register writes are always accepted: index 0 scroll_ticks, index 1 serial_enabled.

module priority_round_robin_call_scanner import prrcs_pkg::*; #(
   parameter int DEVICES = 64
) (
   input  logic        clock,
   input  logic        reset,
   prrcs_req_if.sink   req_ch,
   prrcs_rsp_if.source rsp_ch,
   prrcs_csr_if.sink   csr_ch
);

   localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam int CNT_W = $clog2(DEVICES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEVICES - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_LAST  = 5'b00100,
      ST_FINAL = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // control state
   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   mode_type               saved_mode_ff, saved_mode_in;
   event_type              saved_event_ff, saved_event_in;
   logic [SHOWN_DEV_W-1:0] req_idx_ff, req_idx_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [TICK_W-1:0]      hold_ff, hold_in;
   logic [TICK_W-1:0]      scroll_ff, scroll_in;
   logic                   serial_ff, serial_in;
   logic [DEVICES-1:0]     valid_ff, valid_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   em_found_ff, em_found_in;
   logic                   ca_found_ff, ca_found_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload
   logic                   rd_bit_ff, rd_bit_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]       em_idx_ff, em_idx_in;
   logic [IDX_W-1:0]       ca_idx_ff, ca_idx_in;
   event_type              ca_ev_ff, ca_ev_in;
   logic                   res_shown_ff, res_shown_in;
   event_type              res_event_ff, res_event_in;
   logic [SHOWN_DEV_W-1:0] res_device_ff, res_device_in;
   logic                   rsp_shown_ff, rsp_shown_in;
   event_type              rsp_event_ff, rsp_event_in;
   logic [SHOWN_DEV_W-1:0] rsp_device_ff, rsp_device_in;
   mode_type               rsp_mode_ff, rsp_mode_in;

   // table ram hookup
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [1:0]       ram_rd;
   event_type        ev_rd;

   logic             req_fire;
   logic             dev_ok;
   logic [IDX_W-1:0] scan_start;

   prrcs_ram #(
      .WIDTH (2),
      .DEPTH (DEVICES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.event_code),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd)
   );

   assign req_fire = req_ch.valid && req_ch.ready;
   assign dev_ok   = req_ch.device inside {[DEVICE_W'(1):DEVICE_W'(DEVICES)]};
   assign wr_addr  = IDX_W'(req_ch.device - DEVICE_W'(1));

   // a pointer past the table restarts the walk from device zero
   assign scan_start = (ptr_ff < PTR_W'(DEVICES)) ? IDX_W'(ptr_ff) : '0;

   // entries never written read as cancel
   assign ev_rd = rd_bit_ff ? event_type'(ram_rd) : EV_CANCEL;

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      saved_mode_in  = saved_mode_ff;
      saved_event_in = saved_event_ff;
      req_idx_in     = req_idx_ff;
      ptr_in         = ptr_ff;
      hold_in        = hold_ff;
      scroll_in      = scroll_ff;
      serial_in      = serial_ff;
      valid_in       = valid_ff;
      addr_in        = addr_ff;
      cnt_in         = cnt_ff;
      rd_vld_in      = 1'b0;
      rd_bit_in      = valid_ff[addr_ff];
      rd_idx_in      = addr_ff;
      em_found_in    = em_found_ff;
      em_idx_in      = em_idx_ff;
      ca_found_in    = ca_found_ff;
      ca_idx_in      = ca_idx_ff;
      ca_ev_in       = ca_ev_ff;
      res_shown_in   = res_shown_ff;
      res_event_in   = res_event_ff;
      res_device_in  = res_device_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_shown_in   = rsp_shown_ff;
      rsp_event_in   = rsp_event_ff;
      rsp_device_in  = rsp_device_ff;
      rsp_mode_in    = rsp_mode_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;

      // register writes, indexes past the list fall through
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SCROLL_TICKS: scroll_in = csr_ch.data;
            CSR_SERIAL_EN:    serial_in = csr_ch.data[0];
            default: ;
         endcase
      end

      // collect the first emergency and the first call or assist of the walk
      if (rd_vld_ff) begin
         if ((ev_rd == EV_EMERGENCY) && !em_found_ff) begin
            em_found_in = 1'b1;
            em_idx_in   = rd_idx_ff;
         end
         if ((ev_rd inside {EV_CALL, EV_ASSIST}) && !ca_found_ff) begin
            ca_found_in = 1'b1;
            ca_idx_in   = rd_idx_ff;
            ca_ev_in    = ev_rd;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in      = ST_EMIT;
               res_shown_in  = 1'b0;
               res_event_in  = EV_CANCEL;
               res_device_in = '0;
               case (req_ch.cmd)
                  CMD_TICK: begin
                     if (serial_ff) begin
                        case (mode_ff)
                           MODE_SCAN: begin
                              state_in    = ST_READ;
                              addr_in     = scan_start;
                              cnt_in      = '0;
                              em_found_in = 1'b0;
                              ca_found_in = 1'b0;
                           end
                           MODE_HOLD: begin
                              // at hold expiry release the held entry and step past it
                              if (hold_ff <= TICK_W'(1)) begin
                                 hold_in = '0;
                                 ptr_in  = ptr_ff + PTR_W'(1);
                                 mode_in = MODE_SCAN;
                              end else begin
                                 hold_in = hold_ff - TICK_W'(1);
                              end
                           end
                           MODE_NEWREQ: begin
                              if (saved_event_ff == EV_CANCEL) begin
                                 mode_in = saved_mode_ff;
                              end else begin
                                 hold_in       = scroll_ff;
                                 res_shown_in  = 1'b1;
                                 res_event_in  = saved_event_ff;
                                 res_device_in = req_idx_ff;
                                 ptr_in        = PTR_W'(req_idx_ff);
                                 mode_in       = MODE_HOLD;
                              end
                           end
                           default: ;
                        endcase
                     end
                  end
                  CMD_STORE: begin
                     if (dev_ok) begin
                        wr_en             = 1'b1;
                        valid_in[wr_addr] = 1'b1;
                     end
                  end
                  CMD_NEWREQ: begin
                     // save the request; show a live event now, whatever serial mode is
                     if (dev_ok) begin
                        saved_mode_in  = mode_ff;
                        req_idx_in     = SHOWN_DEV_W'(req_ch.device - DEVICE_W'(1));
                        saved_event_in = req_ch.event_code;
                        if (req_ch.event_code == EV_CANCEL) begin
                           mode_in = mode_ff;
                        end else begin
                           hold_in       = scroll_ff;
                           res_shown_in  = 1'b1;
                           res_event_in  = req_ch.event_code;
                           res_device_in = SHOWN_DEV_W'(req_ch.device - DEVICE_W'(1));
                           ptr_in        = PTR_W'(SHOWN_DEV_W'(req_ch.device - DEVICE_W'(1)));
                           mode_in       = MODE_HOLD;
                        end
                     end
                  end
                  default: begin
                     mode_in = req_ch.mode_value;
                  end
               endcase
            end
         end
         ST_READ: begin
            // one table read per cycle, wrapping at the last device
            rd_en     = 1'b1;
            rd_vld_in = 1'b1;
            rd_idx_in = addr_ff;
            addr_in   = (addr_ff == LAST_IDX) ? '0 : addr_ff + IDX_W'(1);
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DEVICES - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            // last read data is folded in this cycle
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            state_in     = ST_EMIT;
            res_shown_in = 1'b1;
            if (em_found_ff) begin
               ptr_in        = PTR_W'(em_idx_ff);
               mode_in       = MODE_HOLD;
               hold_in       = scroll_ff;
               res_event_in  = EV_EMERGENCY;
               res_device_in = SHOWN_DEV_W'(em_idx_ff);
            end else if (ca_found_ff) begin
               ptr_in        = PTR_W'(ca_idx_ff);
               mode_in       = MODE_HOLD;
               hold_in       = scroll_ff;
               res_event_in  = ca_ev_ff;
               res_device_in = SHOWN_DEV_W'(ca_idx_ff);
            end else begin
               // nothing pending: show cancel and rewind
               ptr_in        = '0;
               res_event_in  = EV_CANCEL;
               res_device_in = '0;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_shown_in  = res_shown_ff;
               rsp_event_in  = res_event_ff;
               rsp_device_in = res_device_ff;
               rsp_mode_in   = mode_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         mode_ff        <= MODE_SCAN;
         saved_mode_ff  <= MODE_SCAN;
         saved_event_ff <= EV_CANCEL;
         req_idx_ff     <= '0;
         ptr_ff         <= '0;
         hold_ff        <= '0;
         scroll_ff      <= SCROLL_RESET;
         serial_ff      <= 1'b1;
         valid_ff       <= '0;
         addr_ff        <= '0;
         cnt_ff         <= '0;
         rd_vld_ff      <= 1'b0;
         em_found_ff    <= 1'b0;
         ca_found_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         saved_mode_ff  <= saved_mode_in;
         saved_event_ff <= saved_event_in;
         req_idx_ff     <= req_idx_in;
         ptr_ff         <= ptr_in;
         hold_ff        <= hold_in;
         scroll_ff      <= scroll_in;
         serial_ff      <= serial_in;
         valid_ff       <= valid_in;
         addr_ff        <= addr_in;
         cnt_ff         <= cnt_in;
         rd_vld_ff      <= rd_vld_in;
         em_found_ff    <= em_found_in;
         ca_found_ff    <= ca_found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_bit_ff     <= rd_bit_in;
      rd_idx_ff     <= rd_idx_in;
      em_idx_ff     <= em_idx_in;
      ca_idx_ff     <= ca_idx_in;
      ca_ev_ff      <= ca_ev_in;
      res_shown_ff  <= res_shown_in;
      res_event_ff  <= res_event_in;
      res_device_ff <= res_device_in;
      rsp_shown_ff  <= rsp_shown_in;
      rsp_event_ff  <= rsp_event_in;
      rsp_device_ff <= rsp_device_in;
      rsp_mode_ff   <= rsp_mode_in;
   end

   // ports
   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.shown_valid  = rsp_shown_ff;
   assign rsp_ch.shown_event  = rsp_event_ff;
   assign rsp_ch.shown_device = rsp_device_ff;
   assign rsp_ch.queue_mode   = rsp_mode_ff;

   // read data only returns during a table walk
   a_read_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_READ || state_ff == ST_LAST))
      else $error("table read data outside a walk");

   // the walk never issues more reads than there are devices
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (cnt_ff < CNT_W'(DEVICES)))
      else $error("table walk overran the device count");

   // a response with no display carries zero event and device
   a_quiet_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_shown_ff) |->
         (rsp_event_ff == EV_CANCEL && rsp_device_ff == '0))
      else $error("quiet response carries display data");

   // a displayed live event always leaves the scanner holding it
   a_hold_after_show: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_shown_ff && rsp_event_ff != EV_CANCEL) |->
         (rsp_mode_ff == MODE_HOLD))
      else $error("shown event without hold mode");

   // an accepted request always leaves idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted but scanner stayed idle");

endmodule
